/* rtl/wpct_pkg.sv */
// Shared types, widths and helpers for the waypoint plane-crossing tracker.
`default_nettype none
package wpct_pkg;

  localparam int MAX_GOALS = 8;
  localparam int SLOT_W    = $clog2(MAX_GOALS);
  localparam int CNT_W     = 4;
  localparam int CRD_W     = 32;
  localparam int RAD_W     = 31;
  localparam int DIFF_W    = CRD_W + 1;
  localparam int DOT_W     = 68;
  localparam int C_W       = 102;
  localparam int RR_W      = 2 * RAD_W;
  localparam int DD_W      = 2 * (DOT_W - 1);
  localparam int OP_W      = 136;
  localparam int PROD_W    = 208;
  localparam int IN_W      = 328;
  localparam int OUT_W     = 104;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 2'd1;

  typedef struct packed {
    logic signed [CRD_W-1:0] gx;
    logic signed [CRD_W-1:0] gy;
    logic signed [CRD_W-1:0] gz;
    logic signed [CRD_W-1:0] nx;
    logic signed [CRD_W-1:0] ny;
    logic signed [CRD_W-1:0] nz;
    logic [CRD_W-1:0]        radius;
  } goal_entry_t;

  localparam int ENTRY_W = $bits(goal_entry_t);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_GO, S_WAIT, S_CHECK, S_ADV, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    ST_DX, ST_PX, ST_DY, ST_PY, ST_DZ, ST_PZ,
    ST_AX, ST_BX, ST_CX, ST_AY, ST_BY, ST_CY, ST_AZ, ST_BZ, ST_CZ,
    ST_RR, ST_DD, ST_RHS
  } step_t;

  function automatic logic signed [OP_W-1:0] ext32(input logic signed [CRD_W-1:0] x);
    return {{(OP_W-CRD_W){x[CRD_W-1]}}, x};
  endfunction

  function automatic logic signed [OP_W-1:0] ext33(input logic signed [DIFF_W-1:0] x);
    return {{(OP_W-DIFF_W){x[DIFF_W-1]}}, x};
  endfunction

  function automatic logic signed [OP_W-1:0] extd(input logic signed [DOT_W-1:0] x);
    return {{(OP_W-DOT_W){x[DOT_W-1]}}, x};
  endfunction

  function automatic logic signed [OP_W-1:0] extc(input logic signed [C_W-1:0] x);
    return {{(OP_W-C_W){x[C_W-1]}}, x};
  endfunction

  function automatic logic [CRD_W-1:0] sat32(input logic signed [DIFF_W-1:0] x);
    logic [CRD_W-1:0] r;
    if (x[DIFF_W-1] != x[DIFF_W-2]) begin
      r = x[DIFF_W-1] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
    end else begin
      r = x[CRD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/wpct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wpct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/wpct_mul.sv */
// Bit-serial signed multiplier, one multiplier bit per cycle, stops early.
`default_nettype none
module wpct_mul (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [wpct_pkg::OP_W-1:0]  a,
  input  wire logic signed [wpct_pkg::OP_W-1:0]  b,
  output logic                                   busy,
  output logic                                   done,
  output logic signed [wpct_pkg::PROD_W-1:0]     product
);

  logic [wpct_pkg::PROD_W-1:0] acc;
  logic [wpct_pkg::PROD_W-1:0] ma;
  logic [wpct_pkg::OP_W-1:0]   mb;
  logic                        neg;
  logic [wpct_pkg::OP_W-1:0]   abs_a;
  logic [wpct_pkg::OP_W-1:0]   abs_b;

  assign abs_a   = a[wpct_pkg::OP_W-1] ? -a : a;
  assign abs_b   = b[wpct_pkg::OP_W-1] ? -b : b;
  assign product = neg ? -acc : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && start) begin
        busy <= 1'b1;
      end else if (busy && mb == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      acc <= '0;
      ma  <= {{(wpct_pkg::PROD_W-wpct_pkg::OP_W){1'b0}}, abs_a};
      mb  <= abs_b;
      neg <= a[wpct_pkg::OP_W-1] ^ b[wpct_pkg::OP_W-1];
    end else if (busy && mb != '0) begin
      if (mb[0]) begin
        acc <= acc + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

endmodule
`default_nettype wire

/* rtl/waypoint_plane_crossing_tracker_core.sv */
// Top level: waypoint table, sample sequencer and result register.
//
//  port group  | dir | moves
//  s_*         | in  | items: tuser = action, tdata = slot, goal, normal, radius, position
//  m_*         | out | results: tdata = goal_index, crossed, offsets
//  cfg_*       | in  | register writes: cfg_index, cfg_data
//
// A table write is done in idle; the block is ready again in the next cycle.
// A sample runs its products one after another on the shared bit-serial multiplier:
// 6 products when the step misses the plane, 18 when it reaches the radius test.
// Reset clears the index, previous position and active flag and sets the goal count to 4; the table is unset.
// A result waits in the output register; a new sample finishing meanwhile holds.
`default_nettype none
module waypoint_plane_crossing_tracker_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // [2:0] goal_slot, [34:3] goal_x, [66:35] goal_y, [98:67] goal_z,
  // [130:99] normal_x, [162:131] normal_y, [194:163] normal_z,
  // [225:195] radius, [257:226] pos_x, [289:258] pos_y, [321:290] pos_z
  input  wire logic [wpct_pkg::IN_W-1:0]              s_tdata,
  // [0] action
  input  wire logic                                   s_tuser,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // [2:0] goal_index, [3] crossed, [35:4] offset_x, [67:36] offset_y, [99:68] offset_z
  output logic [wpct_pkg::OUT_W-1:0]                  m_tdata,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [wpct_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [wpct_pkg::CFG_DAT_W-1:0]         cfg_data
);

  wpct_pkg::state_t state, state_next;
  wpct_pkg::step_t  step;

  logic [wpct_pkg::CNT_W-1:0]  goal_count;
  logic                        active;
  logic [wpct_pkg::SLOT_W-1:0] current_goal;
  logic signed [wpct_pkg::CRD_W-1:0] last_pos [3];
  logic signed [wpct_pkg::CRD_W-1:0] pos [3];
  logic [wpct_pkg::SLOT_W-1:0] idx;
  logic signed [wpct_pkg::DIFF_W-1:0] v_q [3];
  logic signed [wpct_pkg::DIFF_W-1:0] a_q [3];
  logic signed [wpct_pkg::DOT_W-1:0]  d;
  logic signed [wpct_pkg::DOT_W-1:0]  p;
  logic signed [wpct_pkg::C_W-1:0]    c;
  logic signed [wpct_pkg::PROD_W-1:0] lhs;
  logic [wpct_pkg::RR_W-1:0]          rr;
  logic [wpct_pkg::DD_W-1:0]          dd;
  logic                               crossed;

  logic                         s_acc;
  logic                         ram_we, ram_re;
  logic [wpct_pkg::SLOT_W-1:0]  ram_raddr;
  logic [wpct_pkg::ENTRY_W-1:0] ram_rdata;
  wpct_pkg::goal_entry_t        wr_ent, ent;
  logic                         mul_start, mul_busy, mul_done;
  logic signed [wpct_pkg::OP_W-1:0]   op_a, op_b;
  logic signed [wpct_pkg::PROD_W-1:0] prod;

  logic [wpct_pkg::CNT_W-1:0]  cnt_eff;
  logic [wpct_pkg::SLOT_W-1:0] idx_clamped, idx_new;
  logic [1:0]                  ax;
  logic signed [wpct_pkg::CRD_W-1:0]  n_sel;
  logic signed [wpct_pkg::DIFF_W-1:0] v_sel, a_sel;
  logic                         check_ok;
  logic                         out_free;

  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign ent       = wpct_pkg::goal_entry_t'(ram_rdata);

  assign wr_ent.gx     = s_tdata[34:3];
  assign wr_ent.gy     = s_tdata[66:35];
  assign wr_ent.gz     = s_tdata[98:67];
  assign wr_ent.nx     = s_tdata[130:99];
  assign wr_ent.ny     = s_tdata[162:131];
  assign wr_ent.nz     = s_tdata[194:163];
  assign wr_ent.radius = {1'b0, s_tdata[225:195]};

  always_comb begin
    if (goal_count == '0) begin
      cnt_eff = wpct_pkg::CNT_W'(1);
    end else if (goal_count > wpct_pkg::CNT_W'(wpct_pkg::MAX_GOALS)) begin
      cnt_eff = wpct_pkg::CNT_W'(wpct_pkg::MAX_GOALS);
    end else begin
      cnt_eff = goal_count;
    end
  end

  assign idx_clamped = ({1'b0, current_goal} >= cnt_eff) ?
                       wpct_pkg::SLOT_W'(cnt_eff - 1'b1) : current_goal;
  assign idx_new = (crossed && ({1'b0, idx} + 1'b1 < cnt_eff)) ? idx + 1'b1 : idx;

  assign check_ok = !d[wpct_pkg::DOT_W-1] && (d != '0) &&
                    !p[wpct_pkg::DOT_W-1] && (p <= d);

  wpct_ram #(
    .WIDTH (wpct_pkg::ENTRY_W),
    .DEPTH (wpct_pkg::MAX_GOALS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s_tdata[wpct_pkg::SLOT_W-1:0]),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wpct_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (op_a),
    .b       (op_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (prod)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wpct_pkg::S_IDLE: begin
        if (s_acc && s_tuser == wpct_pkg::ACT_SAMPLE && active) begin
          state_next = wpct_pkg::S_FETCH;
        end
      end
      wpct_pkg::S_FETCH: state_next = wpct_pkg::S_GO;
      wpct_pkg::S_GO:    state_next = wpct_pkg::S_WAIT;
      wpct_pkg::S_WAIT: begin
        if (mul_done) begin
          priority if (step == wpct_pkg::ST_PZ) begin
            state_next = wpct_pkg::S_CHECK;
          end else if (step == wpct_pkg::ST_RHS) begin
            state_next = wpct_pkg::S_ADV;
          end else begin
            state_next = wpct_pkg::S_GO;
          end
        end
      end
      wpct_pkg::S_CHECK: state_next = check_ok ? wpct_pkg::S_GO : wpct_pkg::S_ADV;
      wpct_pkg::S_ADV:   state_next = wpct_pkg::S_OUT;
      wpct_pkg::S_OUT: begin
        if (out_free) begin
          state_next = wpct_pkg::S_IDLE;
        end
      end
      default: state_next = wpct_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_clamped;
    mul_start = 1'b0;
    unique case (state)
      wpct_pkg::S_IDLE: begin
        s_tready = 1'b1;
        ram_we   = s_acc && s_tuser == wpct_pkg::ACT_WRITE;
        ram_re   = s_acc && s_tuser == wpct_pkg::ACT_SAMPLE && active;
      end
      wpct_pkg::S_GO: mul_start = 1'b1;
      wpct_pkg::S_ADV: begin
        ram_re    = 1'b1;
        ram_raddr = idx_new;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (step)
      wpct_pkg::ST_DX, wpct_pkg::ST_PX, wpct_pkg::ST_AX,
      wpct_pkg::ST_BX, wpct_pkg::ST_CX: ax = 2'd0;
      wpct_pkg::ST_DY, wpct_pkg::ST_PY, wpct_pkg::ST_AY,
      wpct_pkg::ST_BY, wpct_pkg::ST_CY: ax = 2'd1;
      default:                          ax = 2'd2;
    endcase
  end

  always_comb begin
    unique case (ax)
      2'd0:    n_sel = ent.nx;
      2'd1:    n_sel = ent.ny;
      default: n_sel = ent.nz;
    endcase
    v_sel = (ax == 2'd0) ? v_q[0] : (ax == 2'd1) ? v_q[1] : v_q[2];
    a_sel = (ax == 2'd0) ? a_q[0] : (ax == 2'd1) ? a_q[1] : a_q[2];
  end

  always_comb begin
    unique case (step)
      wpct_pkg::ST_DX, wpct_pkg::ST_DY, wpct_pkg::ST_DZ: begin
        op_a = wpct_pkg::ext32(n_sel);
        op_b = wpct_pkg::ext33(v_sel);
      end
      wpct_pkg::ST_PX, wpct_pkg::ST_PY, wpct_pkg::ST_PZ: begin
        op_a = wpct_pkg::ext32(n_sel);
        op_b = wpct_pkg::ext33(a_sel);
      end
      wpct_pkg::ST_AX, wpct_pkg::ST_AY, wpct_pkg::ST_AZ: begin
        op_a = wpct_pkg::extd(d);
        op_b = wpct_pkg::ext33(a_sel);
      end
      wpct_pkg::ST_BX, wpct_pkg::ST_BY, wpct_pkg::ST_BZ: begin
        op_a = wpct_pkg::extd(p);
        op_b = wpct_pkg::ext33(v_sel);
      end
      wpct_pkg::ST_CX, wpct_pkg::ST_CY, wpct_pkg::ST_CZ: begin
        op_a = wpct_pkg::extc(c);
        op_b = wpct_pkg::extc(c);
      end
      wpct_pkg::ST_RR: begin
        op_a = {{(wpct_pkg::OP_W-wpct_pkg::CRD_W){1'b0}}, ent.radius};
        op_b = {{(wpct_pkg::OP_W-wpct_pkg::CRD_W){1'b0}}, ent.radius};
      end
      wpct_pkg::ST_DD: begin
        op_a = wpct_pkg::extd(d);
        op_b = wpct_pkg::extd(d);
      end
      default: begin
        op_a = {{(wpct_pkg::OP_W-wpct_pkg::DD_W){1'b0}}, dd};
        op_b = {{(wpct_pkg::OP_W-wpct_pkg::RR_W){1'b0}}, rr};
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wpct_pkg::S_IDLE;
      goal_count   <= wpct_pkg::CNT_W'(4);
      active       <= 1'b0;
      current_goal <= '0;
      last_pos[0]  <= '0;
      last_pos[1]  <= '0;
      last_pos[2]  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          wpct_pkg::REG_GOAL_COUNT: goal_count <= cfg_data;
          wpct_pkg::REG_ACTIVE:     active     <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == wpct_pkg::S_ADV) begin
        current_goal <= idx_new;
        last_pos[0]  <= pos[0];
        last_pos[1]  <= pos[1];
        last_pos[2]  <= pos[2];
      end
      if (state == wpct_pkg::S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == wpct_pkg::S_IDLE && ram_re) begin
      pos[0] <= s_tdata[257:226];
      pos[1] <= s_tdata[289:258];
      pos[2] <= s_tdata[321:290];
      idx    <= idx_clamped;
    end
    if (state == wpct_pkg::S_FETCH) begin
      v_q[0] <= {pos[0][31], pos[0]} - {last_pos[0][31], last_pos[0]};
      v_q[1] <= {pos[1][31], pos[1]} - {last_pos[1][31], last_pos[1]};
      v_q[2] <= {pos[2][31], pos[2]} - {last_pos[2][31], last_pos[2]};
      a_q[0] <= {last_pos[0][31], last_pos[0]} - {ent.gx[31], ent.gx};
      a_q[1] <= {last_pos[1][31], last_pos[1]} - {ent.gy[31], ent.gy};
      a_q[2] <= {last_pos[2][31], last_pos[2]} - {ent.gz[31], ent.gz};
      d       <= '0;
      p       <= '0;
      lhs     <= '0;
      step    <= wpct_pkg::ST_DX;
      crossed <= 1'b0;
    end
    if (state == wpct_pkg::S_WAIT && mul_done) begin
      unique case (step)
        wpct_pkg::ST_DX, wpct_pkg::ST_DY, wpct_pkg::ST_DZ:
          d   <= d + prod[wpct_pkg::DOT_W-1:0];
        wpct_pkg::ST_PX, wpct_pkg::ST_PY, wpct_pkg::ST_PZ:
          p   <= p - prod[wpct_pkg::DOT_W-1:0];
        wpct_pkg::ST_AX, wpct_pkg::ST_AY, wpct_pkg::ST_AZ:
          c   <= prod[wpct_pkg::C_W-1:0];
        wpct_pkg::ST_BX, wpct_pkg::ST_BY, wpct_pkg::ST_BZ:
          c   <= c + prod[wpct_pkg::C_W-1:0];
        wpct_pkg::ST_CX, wpct_pkg::ST_CY, wpct_pkg::ST_CZ:
          lhs <= lhs + prod;
        wpct_pkg::ST_RR: rr  <= prod[wpct_pkg::RR_W-1:0];
        wpct_pkg::ST_DD: dd  <= prod[wpct_pkg::DD_W-1:0];
        default:         crossed <= (lhs <= prod);
      endcase
      if (step != wpct_pkg::ST_RHS) begin
        step <= wpct_pkg::step_t'(step + 5'd1);
      end
    end
    if (state == wpct_pkg::S_OUT && out_free) begin
      m_tdata <= {4'b0000,
                  wpct_pkg::sat32({ent.gz[31], ent.gz} - {pos[2][31], pos[2]}),
                  wpct_pkg::sat32({ent.gy[31], ent.gy} - {pos[1][31], pos[1]}),
                  wpct_pkg::sat32({ent.gx[31], ent.gx} - {pos[0][31], pos[0]}),
                  crossed, idx_new};
    end
  end

  a_idle_mul_quiet: assert property (@(posedge clk) disable iff (rst)
    state == wpct_pkg::S_IDLE |-> !mul_busy)
    else $error("multiplier busy while idle");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == wpct_pkg::S_IDLE)
    else $error("table written outside idle");

  a_no_cross_hold: assert property (@(posedge clk) disable iff (rst)
    state == wpct_pkg::S_ADV && !crossed |=> current_goal == $past(idx))
    else $error("index moved without crossing");

  a_start_once: assert property (@(posedge clk) disable iff (rst)
    mul_start |=> mul_busy)
    else $error("multiplier did not start");

endmodule
`default_nettype wire

/* tb/sv/waypoint_plane_crossing_tracker_core_tb.sv */
// Self-checking testbench for the waypoint plane-crossing tracker: directed and random stimulus.
`timescale 1ns / 1ps
module waypoint_plane_crossing_tracker_core_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1000;
  localparam int LONG_HOLD      = 3000;
  localparam logic [wpct_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [wpct_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic              act;
    logic [2:0]        slot;
    logic signed [31:0] g [3];
    logic signed [31:0] n [3];
    logic [30:0]       r;
    logic signed [31:0] pos [3];
  } word_t;

  typedef struct {
    logic [2:0]         idx;
    logic               crossed;
    logic signed [31:0] off [3];
  } fix_t;

  class tracker_board;
    logic signed [31:0] goal_pos [8][3];
    logic signed [31:0] goal_nrm [8][3];
    logic [30:0]        goal_rad [8];
    logic [2:0]         goal_idx;
    logic signed [31:0] last_seen_pos [3];
    logic [3:0]         goal_cnt;
    logic               enabled;
    fix_t               pending_fixes [$];
    int                 mismatches;

    function void clear();
      goal_idx = '0;
      last_seen_pos = '{0, 0, 0};
      goal_cnt = 4'd4;
      enabled = 1'b0;
      mismatches = 0;
      for (int i = 0; i < 8; i++) begin
        goal_pos[i] = '{0, 0, 0};
        goal_nrm[i] = '{0, 0, 0};
        goal_rad[i] = '0;
      end
    endfunction

    function void set_reg(logic [wpct_pkg::CFG_IDX_W-1:0] idx,
                          logic [wpct_pkg::CFG_DAT_W-1:0] data);
      if (idx == wpct_pkg::REG_GOAL_COUNT) goal_cnt = data;
      else if (idx == wpct_pkg::REG_ACTIVE) enabled = data[0];
    endfunction

    function int count_in_use();
      int c;
      c = int'(goal_cnt);
      if (c < 1) c = 1;
      if (c > wpct_pkg::MAX_GOALS) c = wpct_pkg::MAX_GOALS;
      return c;
    endfunction

    function int target_slot();
      int c;
      c = count_in_use();
      return (int'(goal_idx) >= c) ? c - 1 : int'(goal_idx);
    endfunction

    function bit plane_crossed(int s, logic signed [31:0] cur [3]);
      wide_t v [3], a [3], d, p, lhs, rhs, c, rr;
      d = 0; p = 0; lhs = 0;
      for (int i = 0; i < 3; i++) begin
        v[i] = wide_t'(longint'(cur[i]) - longint'(last_seen_pos[i]));
        a[i] = wide_t'(longint'(last_seen_pos[i]) - longint'(goal_pos[s][i]));
        d = d + v[i] * wide_t'(goal_nrm[s][i]);
        p = p - a[i] * wide_t'(goal_nrm[s][i]);
      end
      if (d <= 0) return 0;
      if (p < 0 || p > d) return 0;
      for (int i = 0; i < 3; i++) begin
        c = a[i] * d + p * v[i];
        lhs = lhs + c * c;
      end
      rr = wide_t'({1'b0, goal_rad[s]});
      rhs = rr * rr * d * d;
      return lhs <= rhs;
    endfunction

    function void note(word_t w);
      fix_t f;
      longint diff;
      int c, s;
      if (w.act == wpct_pkg::ACT_WRITE) begin
        goal_pos[w.slot] = w.g;
        goal_nrm[w.slot] = w.n;
        goal_rad[w.slot] = w.r;
        return;
      end
      if (!enabled) return;
      c = count_in_use();
      s = target_slot();
      f.crossed = plane_crossed(s, w.pos);
      if (f.crossed && s + 1 < c) s++;
      goal_idx = 3'(s);
      last_seen_pos = w.pos;
      f.idx = 3'(s);
      for (int i = 0; i < 3; i++) begin
        diff = longint'(goal_pos[s][i]) - longint'(w.pos[i]);
        if (diff > 64'sd2147483647) diff = 64'sd2147483647;
        if (diff < -64'sd2147483648) diff = -64'sd2147483648;
        f.off[i] = diff[31:0];
      end
      pending_fixes.push_back(f);
    endfunction

    function void check(logic [wpct_pkg::OUT_W-1:0] data);
      fix_t e;
      logic signed [31:0] got [3];
      got = '{data[35:4], data[67:36], data[99:68]};
      if (pending_fixes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", data);
        return;
      end
      e = pending_fixes.pop_front();
      if (e.idx !== data[2:0] || e.crossed !== data[3] || e.off[0] !== got[0] ||
          e.off[1] !== got[1] || e.off[2] !== got[2]) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp idx %0d crossed %0d off %0d %0d %0d, ",
                    "got idx %0d crossed %0d off %0d %0d %0d"},
                   e.idx, e.crossed, e.off[0], e.off[1], e.off[2],
                   data[2:0], data[3], got[0], got[1], got[2]);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [wpct_pkg::IN_W-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [wpct_pkg::OUT_W-1:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [wpct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wpct_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  tracker_board board = new();
  bit quiet = 0;
  bit long_hold_req = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  waypoint_plane_crossing_tracker_core dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = LONG_HOLD;
    end else if (hold_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 14);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check(m_tdata);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [wpct_pkg::IN_W-1:0] pack_word(word_t w);
    return {6'b0, w.pos[2], w.pos[1], w.pos[0], w.r, w.n[2], w.n[1], w.n[0],
            w.g[2], w.g[1], w.g[0], w.slot};
  endfunction

  task automatic send(word_t w);
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = w.act;
    s_tdata = pack_word(w);
    do @(posedge clk); while (!s_tready);
    board.note(w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.pending_fixes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [wpct_pkg::CFG_IDX_W-1:0] idx,
                           logic [wpct_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic word_t noise_word(logic act);
    word_t w;
    w.act = act;
    w.slot = 3'($urandom);
    for (int i = 0; i < 3; i++) begin
      w.g[i] = $urandom;
      w.n[i] = $urandom;
      w.pos[i] = $urandom;
    end
    w.r = 31'($urandom);
    return w;
  endfunction

  function automatic word_t goal_word(logic [2:0] slot);
    word_t w;
    w = noise_word(wpct_pkg::ACT_WRITE);
    w.slot = slot;
    for (int i = 0; i < 3; i++) begin
      w.g[i] = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      w.n[i] = $signed($urandom_range(0, 4000)) - 2000;
    end
    w.r = 31'($urandom_range(3000, 60000));
    return w;
  endfunction

  // position behind (ahead=0) or past the current goal's plane, near its centre
  function automatic word_t pass_word(bit ahead);
    word_t w;
    int s;
    w = noise_word(wpct_pkg::ACT_SAMPLE);
    s = board.target_slot();
    for (int i = 0; i < 3; i++) begin
      w.pos[i] = board.goal_pos[s][i]
                 + (ahead ? board.goal_nrm[s][i] : -board.goal_nrm[s][i])
                 + ($signed($urandom_range(0, 400)) - 200);
    end
    return w;
  endfunction

  task automatic random_phase(int items);
    int k;
    k = 0;
    while (k < items) begin
      case ($urandom_range(0, 9))
        0: begin
          send(goal_word(3'($urandom)));
          k++;
        end
        1: begin
          send($urandom_range(0, 3) == 0 ? noise_word(wpct_pkg::ACT_WRITE)
                                         : noise_word(wpct_pkg::ACT_SAMPLE));
          k++;
        end
        default: begin
          send(pass_word(0));
          send(pass_word(1));
          k += 2;
        end
      endcase
    end
  endtask

  initial begin
    word_t w;
    board.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    for (int s = 0; s < 8; s++) send(goal_word(3'(s)));
    w = noise_word(wpct_pkg::ACT_WRITE);
    w.slot = 3'd7;
    w.g = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    w.n = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    w.r = 31'h7fffffff;
    send(w);
    send(noise_word(wpct_pkg::ACT_SAMPLE));
    drain();
    cfg_write(wpct_pkg::REG_ACTIVE, 4'd1);
    cfg_write(wpct_pkg::REG_GOAL_COUNT, 4'd8);
    send(pass_word(0));
    send(pass_word(0));
    send(pass_word(1));
    send(pass_word(0));
    w = pass_word(1);
    send(w);
    send(w);
    w.pos = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    send(w);
    w.pos = '{32'sh7fffffff, 32'sh80000000, 32'sh0};
    send(w);
    for (int i = 0; i < 6; i++) send(pass_word(i % 2));
    drain();

    cfg_write(REG_SPARE_2, 4'hf);
    cfg_write(REG_SPARE_3, 4'h0);
    fork
      random_phase(60);
      begin
        repeat (200) @(posedge clk);
        long_hold_req = 1;
      end
    join
    drain();
    cfg_write(wpct_pkg::REG_GOAL_COUNT, 4'd1);
    random_phase(40);
    drain();
    cfg_write(wpct_pkg::REG_GOAL_COUNT, 4'd15);
    random_phase(50);
    drain();
    cfg_write(wpct_pkg::REG_GOAL_COUNT, 4'd2);
    random_phase(40);
    drain();
    cfg_write(wpct_pkg::REG_ACTIVE, 4'd0);
    random_phase(20);
    drain();
    cfg_write(wpct_pkg::REG_GOAL_COUNT, 4'd0);
    cfg_write(wpct_pkg::REG_ACTIVE, 4'd1);
    random_phase(40);
    drain();
    cfg_write(wpct_pkg::REG_GOAL_COUNT, 4'd5);
    random_phase(60);
    drain();
    cfg_write(wpct_pkg::REG_GOAL_COUNT, 4'd3);
    quiet = 1;
    random_phase(60);
    drain();

    if (board.mismatches == 0 && board.pending_fixes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
